// ===== hdl/trilateration_2d_solver_defines.svh =====
// Assertion macros shared by the trilateration solver checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TRILATERATION_2D_SOLVER_DEFINES_SVH
`define TRILATERATION_2D_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TRI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed number of cycles between cause and effect.
`define TRI_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== hdl/trilat_pkg.sv =====
// Package for the trilateration solver: field widths, pipeline types and helpers.
// No dependencies; used by trilateration_2d_solver and trilat_chk.
package trilat_pkg;

  localparam int CW      = 24;        // coordinate width
  localparam int RW      = CW - 1;    // range width
  localparam int SQW     = 2 * CW - 1; // square magnitude width
  localparam int KW      = CW + 2;    // A, B, D, E width
  localparam int CFW     = 2 * CW + 1; // C, F width
  localparam int CLW     = 25;        // low split of C and F
  localparam int CHW     = CFW - CLW; // high split of C and F
  localparam int DW      = 2 * KW;    // determinant width
  localparam int NW      = CFW + KW;  // numerator width
  localparam int OW      = 32;        // output width
  localparam int DMW     = 50;        // det_min width
  localparam int QSTEPS  = OW;        // one quotient bit per stage
  localparam int LATENCY = 5 + QSTEPS + 1;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [OW-1:0] low;
    logic [OW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic        sing;
    logic        neg_x;
    logic        neg_y;
    logic        ovf_x;
    logic        ovf_y;
    logic [DW-1:0] dmag;
  } dctl_t;

  function automatic logic signed [KW-1:0] dbl_diff(logic signed [CW-1:0] a,
                                                    logic signed [CW-1:0] b);
    logic signed [CW:0] dif;
    dif = {a[CW-1], a} - {b[CW-1], b};
    return {dif, 1'b0};
  endfunction

  function automatic logic [SQW-1:0] sq_s(logic signed [CW-1:0] v);
    logic signed [2*CW-1:0] p;
    p = v * v;
    return p[SQW-1:0];
  endfunction

  function automatic logic [SQW-1:0] sq_u(logic [RW-1:0] v);
    logic [2*RW-1:0] p;
    p = v * v;
    return {1'b0, p};
  endfunction

  // One restoring division step; the remainder stays below the divisor.
  function automatic lane_t div_step(lane_t l, logic [DW-1:0] d);
    logic [DW:0] t;
    logic        qb;
    lane_t       r;
    t  = {l.rem, l.low[OW-1]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    r.rem = t[DW-1:0];
    r.low = {l.low[OW-2:0], 1'b0};
    r.q   = {l.q[OW-2:0], qb};
    return r;
  endfunction

  // Applies the sign and saturates; the top bit of the result is the clip flag.
  function automatic logic [OW:0] sat_out(logic [OW-1:0] q, logic neg, logic ovf);
    logic [OW-1:0] v;
    logic          c;
    if (!neg) begin
      c = ovf || q[OW-1];
      v = c ? {1'b0, {(OW-1){1'b1}}} : q;
    end else begin
      c = ovf || (q[OW-1] && (q[OW-2:0] != '0));
      v = c ? {1'b1, {(OW-1){1'b0}}} : (~q + 1'b1);
    end
    return {c, v};
  endfunction

endpackage

// ===== hdl/trilateration_2d_solver.sv =====
// Top level of the three-anchor 2D trilateration solver, fully pipelined.
// Depends on trilat_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  command   | start / busy         | anchor1..3_x, anchor1..3_y, range1..3
//  config    | cfg_valid / cfg_ready| cfg_data (det_min)
//  result    | done (strobe)        | pos_x, pos_y, singular, clipped
//
// One transaction is accepted every cycle; busy is never raised.
// A result passes through five arithmetic stages, 32 stages of the divider
// (one quotient bit per stage per coordinate) and the output register.
// rst clears the valid bits of the pipeline and sets det_min to 1.
// The receiver cannot stall, so the pipeline never holds.
module trilateration_2d_solver (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [trilat_pkg::CW-1:0]     anchor1_x,
  input  logic signed [trilat_pkg::CW-1:0]     anchor1_y,
  input  logic        [trilat_pkg::RW-1:0]     range1,
  input  logic signed [trilat_pkg::CW-1:0]     anchor2_x,
  input  logic signed [trilat_pkg::CW-1:0]     anchor2_y,
  input  logic        [trilat_pkg::RW-1:0]     range2,
  input  logic signed [trilat_pkg::CW-1:0]     anchor3_x,
  input  logic signed [trilat_pkg::CW-1:0]     anchor3_y,
  input  logic        [trilat_pkg::RW-1:0]     range3,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [trilat_pkg::DMW-1:0]    cfg_data,
  output logic                                 done,
  output logic signed [trilat_pkg::OW-1:0]     pos_x,
  output logic signed [trilat_pkg::OW-1:0]     pos_y,
  output logic                                 singular,
  output logic                                 clipped
);
  import trilat_pkg::*;

  logic [DMW-1:0] det_min;

  // Stage 1: differences and squares.
  logic                   v1;
  logic signed [KW-1:0]   s1_a, s1_b, s1_d, s1_e;
  logic [SQW-1:0]         s1_r1, s1_r2, s1_r3, s1_x1, s1_x2, s1_x3, s1_y1, s1_y2, s1_y3;
  // Stage 2: right-hand sides and determinant products.
  logic                   v2;
  logic signed [KW-1:0]   s2_a, s2_b, s2_d, s2_e;
  logic signed [CFW-1:0]  s2_c, s2_f;
  logic signed [DW-1:0]   s2_ae, s2_bd;
  // Stage 3: determinant and partial products of the numerators.
  logic                   v3;
  logic signed [DW-1:0]   s3_det;
  logic signed [CHW+KW-1:0] s3_ceh, s3_fbh, s3_afh, s3_dch;
  logic signed [DW-1:0]   s3_cel, s3_fbl, s3_afl, s3_dcl;
  // Stage 4: numerators and singularity test.
  logic                   v4;
  logic signed [NW-1:0]   s4_nx, s4_ny;
  logic signed [DW-1:0]   s4_det;
  logic                   s4_sing;
  // Divider pipeline, index 0 is loaded from stage 4.
  lane_t                  lx [0:QSTEPS];
  lane_t                  ly [0:QSTEPS];
  dctl_t                  dc [0:QSTEPS];
  logic                   dv [0:QSTEPS];

  logic                   accept;
  logic [DW-1:0]          s4_dmag;
  logic [NW-1:0]          s4_mx, s4_my;
  logic [OW:0]            res_x, res_y;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_min <= DMW'(1);
    end else if (cfg_valid && cfg_ready) begin
      det_min <= cfg_data;
    end
  end

  always_comb begin
    s4_dmag = s4_det[DW-1] ? DW'(-s4_det) : DW'(s4_det);
    s4_mx   = s4_nx[NW-1] ? NW'(-s4_nx) : NW'(s4_nx);
    s4_my   = s4_ny[NW-1] ? NW'(-s4_ny) : NW'(s4_ny);
    res_x   = sat_out(lx[QSTEPS].q, dc[QSTEPS].neg_x, dc[QSTEPS].ovf_x);
    res_y   = sat_out(ly[QSTEPS].q, dc[QSTEPS].neg_y, dc[QSTEPS].ovf_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
      for (int k = 0; k <= QSTEPS; k++) begin
        dv[k] <= 1'b0;
      end
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dv[0] <= v4;
      for (int k = 1; k <= QSTEPS; k++) begin
        dv[k] <= dv[k-1];
      end
      done <= dv[QSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    s1_a  <= dbl_diff(anchor1_x, anchor2_x);
    s1_b  <= dbl_diff(anchor1_y, anchor2_y);
    s1_d  <= dbl_diff(anchor1_x, anchor3_x);
    s1_e  <= dbl_diff(anchor1_y, anchor3_y);
    s1_r1 <= sq_u(range1);
    s1_r2 <= sq_u(range2);
    s1_r3 <= sq_u(range3);
    s1_x1 <= sq_s(anchor1_x);
    s1_x2 <= sq_s(anchor2_x);
    s1_x3 <= sq_s(anchor3_x);
    s1_y1 <= sq_s(anchor1_y);
    s1_y2 <= sq_s(anchor2_y);
    s1_y3 <= sq_s(anchor3_y);

    s2_a  <= s1_a;
    s2_b  <= s1_b;
    s2_d  <= s1_d;
    s2_e  <= s1_e;
    s2_c  <= $signed(CFW'(s1_r1)) - $signed(CFW'(s1_x1)) - $signed(CFW'(s1_y1))
           - $signed(CFW'(s1_r2)) + $signed(CFW'(s1_x2)) + $signed(CFW'(s1_y2));
    s2_f  <= $signed(CFW'(s1_r1)) - $signed(CFW'(s1_x1)) - $signed(CFW'(s1_y1))
           - $signed(CFW'(s1_r3)) + $signed(CFW'(s1_x3)) + $signed(CFW'(s1_y3));
    s2_ae <= s1_a * s1_e;
    s2_bd <= s1_b * s1_d;

    // C and F are split so that each product stays near 26 by 26 bits.
    s3_det <= s2_ae - s2_bd;
    s3_ceh <= $signed(s2_c[CFW-1:CLW]) * s2_e;
    s3_fbh <= $signed(s2_f[CFW-1:CLW]) * s2_b;
    s3_afh <= $signed(s2_f[CFW-1:CLW]) * s2_a;
    s3_dch <= $signed(s2_c[CFW-1:CLW]) * s2_d;
    s3_cel <= $signed({1'b0, s2_c[CLW-1:0]}) * s2_e;
    s3_fbl <= $signed({1'b0, s2_f[CLW-1:0]}) * s2_b;
    s3_afl <= $signed({1'b0, s2_f[CLW-1:0]}) * s2_a;
    s3_dcl <= $signed({1'b0, s2_c[CLW-1:0]}) * s2_d;

    s4_nx   <= NW'((NW'(s3_ceh - s3_fbh) <<< CLW) + NW'(s3_cel - s3_fbl));
    s4_ny   <= NW'((NW'(s3_afh - s3_dch) <<< CLW) + NW'(s3_afl - s3_dcl));
    s4_det  <= s3_det;
    s4_sing <= (s3_det == '0) ||
               ((s3_det[DW-1] ? DW'(-s3_det) : DW'(s3_det)) < DW'(det_min));

    // Quotients of 2^32 or more are only flagged; the divider then covers 32 bits.
    lx[0].rem   <= DW'(s4_mx[NW-1:OW]);
    lx[0].low   <= s4_mx[OW-1:0];
    lx[0].q     <= '0;
    ly[0].rem   <= DW'(s4_my[NW-1:OW]);
    ly[0].low   <= s4_my[OW-1:0];
    ly[0].q     <= '0;
    dc[0].sing  <= s4_sing;
    dc[0].neg_x <= s4_nx[NW-1] != s4_det[DW-1];
    dc[0].neg_y <= s4_ny[NW-1] != s4_det[DW-1];
    dc[0].ovf_x <= {{(DW+OW-NW){1'b0}}, s4_mx} >= {s4_dmag, {OW{1'b0}}};
    dc[0].ovf_y <= {{(DW+OW-NW){1'b0}}, s4_my} >= {s4_dmag, {OW{1'b0}}};
    dc[0].dmag  <= s4_dmag;

    for (int k = 1; k <= QSTEPS; k++) begin
      lx[k]       <= div_step(lx[k-1], dc[k-1].dmag);
      ly[k]       <= div_step(ly[k-1], dc[k-1].dmag);
      dc[k].sing  <= dc[k-1].sing;
      dc[k].neg_x <= dc[k-1].neg_x;
      dc[k].neg_y <= dc[k-1].neg_y;
      dc[k].ovf_x <= dc[k-1].ovf_x;
      dc[k].ovf_y <= dc[k-1].ovf_y;
      dc[k].dmag  <= dc[k-1].dmag;
    end

    if (dc[QSTEPS].sing) begin
      pos_x   <= '0;
      pos_y   <= '0;
      clipped <= 1'b0;
    end else begin
      pos_x   <= res_x[OW-1:0];
      pos_y   <= res_y[OW-1:0];
      clipped <= res_x[OW] || res_y[OW];
    end
    singular <= dc[QSTEPS].sing;
  end

endmodule

// ===== hdl/trilat_chk.sv =====
// Port-level checker for the trilateration solver, bound to the top level.
// Depends on trilat_pkg and trilateration_2d_solver_defines.svh.
`include "trilateration_2d_solver_defines.svh"

module trilat_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [trilat_pkg::OW-1:0]  pos_x,
  input logic signed [trilat_pkg::OW-1:0]  pos_y,
  input logic                              singular,
  input logic                              clipped
);
  import trilat_pkg::*;

  localparam logic [OW-1:0] SAT_HI = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SAT_LO = {1'b1, {(OW-1){1'b0}}};

  `TRI_ASSERT_DELAY(a_latency, start && !busy, 38, done, "result missing after a command")
  `TRI_ASSERT_NOW(a_no_orphan, done, $past(start && !busy, LATENCY), "result without a command")
  `TRI_ASSERT_NOW(a_sing_zero, done && singular, pos_x == '0 && pos_y == '0 && !clipped, "singular result not zeroed")
  `TRI_ASSERT_NOW(a_clip_sat, done && clipped, pos_x == SAT_HI || pos_x == SAT_LO || pos_y == SAT_HI || pos_y == SAT_LO, "clipped result not saturated")

endmodule

bind trilateration_2d_solver trilat_chk u_trilat_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .pos_x(pos_x), .pos_y(pos_y), .singular(singular), .clipped(clipped)
);

// ===== tb/trilateration_2d_solver_test.sv =====
// Testbench for trilateration_2d_solver: drives position-fix commands and det_min
// writes, predicts each fix with exact wide arithmetic and checks every result.
// Depends on trilat_pkg and the trilateration_2d_solver RTL.
module trilateration_2d_solver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trilat_pkg::*;

  typedef struct {
    logic signed [CW-1:0] ax1, ay1;
    logic [RW-1:0]        r1;
    logic signed [CW-1:0] ax2, ay2;
    logic [RW-1:0]        r2;
    logic signed [CW-1:0] ax3, ay3;
    logic [RW-1:0]        r3;
  } fix_cmd_t;

  typedef struct {
    logic signed [OW-1:0] px, py;
    logic                 sing, clip;
  } fix_res_t;

  class fix_scoreboard;
    fix_res_t       pending[$];
    logic [DMW-1:0] det_floor;
    int             errors;

    function new();
      det_floor = 1;
      errors = 0;
    endfunction

    // Truncated quotient, saturated to 32 bits.
    function automatic logic signed [OW-1:0] quot(logic signed [127:0] n,
                                                   logic signed [127:0] d,
                                                   ref logic clip);
      logic signed [127:0] q;
      q = n / d;
      if (q > 128'sd2147483647) begin
        clip = 1'b1;
        return 32'sh7fffffff;
      end
      if (q < -128'sd2147483648) begin
        clip = 1'b1;
        return 32'sh80000000;
      end
      return q[OW-1:0];
    endfunction

    function void note_fix(fix_cmd_t c);
      logic signed [127:0] a, b, d, e, base, cc, ff, det, mag;
      fix_res_t r;
      logic clip;
      a = 2 * (128'(c.ax1) - 128'(c.ax2));
      b = 2 * (128'(c.ay1) - 128'(c.ay2));
      d = 2 * (128'(c.ax1) - 128'(c.ax3));
      e = 2 * (128'(c.ay1) - 128'(c.ay3));
      base = 128'(c.r1) * 128'(c.r1) - 128'(c.ax1) * 128'(c.ax1)
             - 128'(c.ay1) * 128'(c.ay1);
      cc = base - 128'(c.r2) * 128'(c.r2) + 128'(c.ax2) * 128'(c.ax2)
           + 128'(c.ay2) * 128'(c.ay2);
      ff = base - 128'(c.r3) * 128'(c.r3) + 128'(c.ax3) * 128'(c.ax3)
           + 128'(c.ay3) * 128'(c.ay3);
      det = a * e - b * d;
      mag = det < 0 ? -det : det;
      clip = 1'b0;
      if (mag == 0 || mag < 128'($unsigned(det_floor))) begin
        r = '{0, 0, 1'b1, 1'b0};
      end else begin
        r.px = quot(cc * e - ff * b, det, clip);
        r.py = quot(a * ff - d * cc, det, clip);
        r.sing = 1'b0;
        r.clip = clip;
      end
      pending.push_back(r);
    endfunction

    function void check_fix(fix_res_t got);
      fix_res_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $realtime, got.px, got.py);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.px !== w.px) begin
        $display("%0t: pos_x expected %0d actual %0d", $realtime, w.px, got.px);
        errors++;
      end
      if (got.py !== w.py) begin
        $display("%0t: pos_y expected %0d actual %0d", $realtime, w.py, got.py);
        errors++;
      end
      if (got.sing !== w.sing) begin
        $display("%0t: singular expected %0b actual %0b", $realtime, w.sing, got.sing);
        errors++;
      end
      if (got.clip !== w.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $realtime, w.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_CYCLES = 5000;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, busy;
  logic signed [CW-1:0] anchor1_x = '0, anchor1_y = '0, anchor2_x = '0;
  logic signed [CW-1:0] anchor2_y = '0, anchor3_x = '0, anchor3_y = '0;
  logic [RW-1:0] range1 = '0, range2 = '0, range3 = '0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [DMW-1:0] cfg_data = '0;
  logic done, singular, clipped;
  logic signed [OW-1:0] pos_x, pos_y;

  fix_scoreboard board = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  trilateration_2d_solver uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_fix('{pos_x, pos_y, singular, clipped});
    end
    if (!rst && ((start && !busy) || done || (cfg_valid && cfg_ready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("trilateration_2d_solver verification failed");
      $finish;
    end
  end

  // Leaves start high on return; an idle cycle or the caller drops it.
  task automatic send_fix(fix_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    anchor1_x <= c.ax1; anchor1_y <= c.ay1; range1 <= c.r1;
    anchor2_x <= c.ax2; anchor2_y <= c.ay2; range2 <= c.r2;
    anchor3_x <= c.ax3; anchor3_y <= c.ay3; range3 <= c.r3;
    do @(posedge clk); while (busy);
    board.note_fix(c);
    @(negedge clk);
  endtask

  // Writes det_min once the pipeline has drained.
  task automatic write_det_floor(logic [DMW-1:0] v);
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.det_floor = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rnd_coord(int span);
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'(int'($urandom_range(2 * span)) - span);
      2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return CW'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic fix_cmd_t rnd_fix();
    fix_cmd_t c;
    int span;
    span = $urandom_range(1) ? 4000 : 8388607;
    c.ax1 = rnd_coord(span); c.ay1 = rnd_coord(span);
    c.ax2 = rnd_coord(span); c.ay2 = rnd_coord(span);
    c.ax3 = rnd_coord(span); c.ay3 = rnd_coord(span);
    if ($urandom_range(9) == 0) begin
      c.ax3 = c.ax2; c.ay3 = c.ay2;   // collinear pair, zero determinant
    end
    c.r1 = $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(span));
    c.r2 = $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(span));
    c.r3 = $urandom_range(3) == 0 ? 23'($urandom) : 23'($urandom_range(span));
    return c;
  endfunction

  initial begin
    fix_cmd_t c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a plain triangle, extremes, degenerate and clipping geometry.
    send_fix('{0, 0, 2560, 0, 2560, 0, 0, 0, 0});
    send_fix('{0, 0, 1000, 2560, 0, 1500, 0, 2560, 1200});
    send_fix('{24'sh7fffff, 24'sh7fffff, 23'h7fffff, 24'sh800000, 24'sh800000,
               23'h7fffff, 24'sh800000, 24'sh7fffff, 0});
    send_fix('{24'sh800000, 24'sh800000, 0, 24'sh7fffff, 24'sh800000, 0,
               24'sh800000, 24'sh7fffff, 23'h7fffff});
    send_fix('{5, 5, 3, 5, 5, 3, 5, 5, 3});
    send_fix('{0, 0, 0, 1, 0, 0, 2, 0, 0});
    send_fix('{0, 0, 23'h7fffff, 1, 0, 0, 0, 1, 0});
    send_fix('{0, 0, 0, 1, 0, 23'h7fffff, 0, 1, 23'h7fffff});
    send_fix('{0, 0, 23'h7fffff, 0, 1, 0, 1, 0, 0});
    write_det_floor('0);
    send_fix('{7, 7, 10, 7, 7, 10, 7, 7, 10});
    send_fix('{0, 0, 256, 256, 0, 256, 0, 256, 256});
    write_det_floor(50'h3ffffffffffff);
    send_fix('{24'sh7fffff, 24'sh800000, 5, 24'sh800000, 24'sh7fffff, 6,
               24'sh800000, 24'sh800000, 7});
    send_fix('{0, 0, 256, 256, 0, 256, 0, 256, 256});
    write_det_floor(50'd262144);
    send_fix('{0, 0, 256, 256, 0, 256, 0, 256, 256});
    send_fix('{0, 0, 256, 255, 0, 256, 0, 256, 256});

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase == 0 ? 24 : (phase == 1 ? 71 : 0);
      case (phase)
        0: write_det_floor(1);
        1: write_det_floor(50'($urandom_range(1 << 20)));
        default: write_det_floor(50'({$urandom, $urandom}));
      endcase
      for (int i = 0; i < 200; i++) begin
        c = rnd_fix();
        send_fix(c);
      end
    end

    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("trilateration_2d_solver verification clean");
    end else begin
      $display("trilateration_2d_solver verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/trilat_pkg.sv
hdl/trilateration_2d_solver.sv
hdl/trilat_chk.sv
tb/trilateration_2d_solver_test.sv
